// File: design/u8v_pkg.sv
// u8v_pkg: shared types and constants for the utf-8 stream validator
// no dependencies; used by u8v_step, utf8_stream_validator and the bench
`default_nettype none

package u8v_pkg;

    // lead byte tags, compared against the top bits of a byte
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;
    localparam logic [1:0] CONT_TAG  = 2'b10;

    // sequence length codes (length minus one)
    localparam logic [1:0] SEQ_NONE = 2'd0;
    localparam logic [1:0] SEQ_TWO  = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR = 2'd3;

    localparam int unsigned CP_W = 21;

    // smallest code point allowed for each sequence length
    localparam logic [CP_W-1:0] FLOOR_TWO   = 21'h00_0080;
    localparam logic [CP_W-1:0] FLOOR_THREE = 21'h00_0800;
    localparam logic [CP_W-1:0] FLOOR_FOUR  = 21'h01_0000;

    // per-string decoder state
    typedef struct packed {
        logic [1:0]      pending;   // continuation bytes still due
        logic [1:0]      seq_len;   // open sequence length minus one
        logic [CP_W-1:0] cp;        // code point bits gathered so far
        logic            err;       // sticky error for this string
    } t_dec_state;

endpackage

`default_nettype wire

// File: design/u8v_byte_if.sv
// u8v_byte_if: valid/ready channel carrying one string byte per request
// no dependencies
`default_nettype none

interface u8v_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// File: design/u8v_verdict_if.sv
// u8v_verdict_if: valid/ready channel carrying one verdict per string
// no dependencies
`default_nettype none

interface u8v_verdict_if;
    logic valid;
    logic ready;
    logic string_valid;

    modport source (output valid, output string_valid, input ready);
    modport sink   (input valid, input string_valid, output ready);
endinterface

`default_nettype wire

// File: design/u8v_step.sv
// u8v_step: next-state logic for one byte of the utf-8 decoder
// depends on u8v_pkg
`default_nettype none

module u8v_step (
    input  u8v_pkg::t_dec_state i_state,
    input  logic [7:0]          i_data_byte,
    input  logic                i_final_byte,
    output u8v_pkg::t_dec_state o_state,
    output logic                o_string_valid
);

    u8v_pkg::t_dec_state s;
    logic [u8v_pkg::CP_W-1:0] cp_shift;
    logic [u8v_pkg::CP_W-1:0] floor_value;

    always_comb begin
        s           = i_state;
        cp_shift    = {i_state.cp[u8v_pkg::CP_W-7:0], i_data_byte[5:0]};
        floor_value = u8v_pkg::FLOOR_FOUR;

        unique case (i_state.seq_len)
            u8v_pkg::SEQ_TWO:   floor_value = u8v_pkg::FLOOR_TWO;
            u8v_pkg::SEQ_THREE: floor_value = u8v_pkg::FLOOR_THREE;
            default:            floor_value = u8v_pkg::FLOOR_FOUR;
        endcase

        if (i_state.pending == 2'd0) begin
            // lead byte
            priority if (i_data_byte[7] == 1'b0) begin
                s = i_state;
            end else if (i_data_byte[7:5] == u8v_pkg::LEAD2_TAG) begin
                s.pending = 2'd1;
                s.seq_len = u8v_pkg::SEQ_TWO;
                s.cp      = {16'd0, i_data_byte[4:0]};
            end else if (i_data_byte[7:4] == u8v_pkg::LEAD3_TAG) begin
                s.pending = 2'd2;
                s.seq_len = u8v_pkg::SEQ_THREE;
                s.cp      = {17'd0, i_data_byte[3:0]};
            end else if (i_data_byte[7:3] == u8v_pkg::LEAD4_TAG) begin
                s.pending = 2'd3;
                s.seq_len = u8v_pkg::SEQ_FOUR;
                s.cp      = {18'd0, i_data_byte[2:0]};
            end else begin
                // stray continuation or 11111xxx
                s.err = 1'b1;
            end
        end else if (i_data_byte[7:6] != u8v_pkg::CONT_TAG) begin
            // broken sequence: drop it
            s.err     = 1'b1;
            s.pending = 2'd0;
            s.seq_len = u8v_pkg::SEQ_NONE;
            s.cp      = '0;
        end else if (i_state.pending == 2'd1) begin
            // last continuation: overlong check
            if (cp_shift < floor_value) begin
                s.err = 1'b1;
            end
            s.pending = 2'd0;
            s.seq_len = u8v_pkg::SEQ_NONE;
            s.cp      = '0;
        end else begin
            s.pending = i_state.pending - 2'd1;
            s.cp      = cp_shift;
        end

        // sticky error, or a truncated sequence at the end of the string
        o_string_valid = !(s.err || (s.pending != 2'd0));

        if (i_final_byte) begin
            o_state = '0;
        end else begin
            o_state = s;
        end
    end

endmodule

`default_nettype wire

// File: design/utf8_stream_validator.sv
// utf8_stream_validator: streaming utf-8 well-formedness checker, top level
// depends on u8v_pkg, u8v_byte_if, u8v_verdict_if, u8v_step
//
//  channel    dir  fields                     per request
//  i_byte     in   data_byte[7:0], final_byte one byte of a string
//  o_verdict  out  string_valid               one verdict per string
//
// one byte per cycle sustained while no verdict stalls; a byte is registered
// in the input register on acceptance and decoded from there; a final byte
// also loads its verdict into the result register, which drives o_verdict.
// synchronous active-low reset clears the decoder state and both valid flags.
// a stalled verdict holds only final bytes in the input register; other bytes
// keep flowing, and one byte can wait in the input register meanwhile.
`default_nettype none

module utf8_stream_validator (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    u8v_byte_if.sink              i_byte,
    u8v_verdict_if.source         o_verdict
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_final;

    // decoder state
    u8v_pkg::t_dec_state r_state;
    u8v_pkg::t_dec_state n_state;
    logic                step_valid;

    // result register
    logic r_out_valid;
    logic r_out_bit;

    logic out_free;
    logic stage_fire;
    logic in_take;

    // result slot is free if empty or being drained this cycle
    assign out_free   = !r_out_valid || o_verdict.ready;
    // non-final bytes never need the result slot
    assign stage_fire = r_in_valid && (!r_in_final || out_free);
    assign i_byte.ready = !r_in_valid || stage_fire;
    assign in_take    = i_byte.valid && i_byte.ready;

    u8v_step u_step (
        .i_state        (r_state),
        .i_data_byte    (r_in_byte),
        .i_final_byte   (r_in_final),
        .o_state        (n_state),
        .o_string_valid (step_valid)
    );

    // input register: valid is control, payload is loaded on take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (stage_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte  <= i_byte.data_byte;
            r_in_final <= i_byte.final_byte;
        end
    end

    // decoder state advances once per decoded byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (stage_fire) begin
            r_state <= n_state;
        end
    end

    // verdict register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_fire && r_in_final) begin
            r_out_valid <= 1'b1;
        end else if (o_verdict.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_fire && r_in_final) begin
            r_out_bit <= step_valid;
        end
    end

    assign o_verdict.valid        = r_out_valid;
    assign o_verdict.string_valid = r_out_bit;

    // a final byte leaves the decoder clean for the next string
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_fire && r_in_final) |=> (r_state == '0))
        else $error("decoder state not cleared after final byte");

    // an open sequence always has a length that covers what is pending
    a_pending_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.pending <= r_state.seq_len))
        else $error("pending count exceeds sequence length");

    // a verdict waiting on a stall is never overwritten
    a_verdict_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_verdict.ready) |-> !(stage_fire && r_in_final))
        else $error("verdict overwritten while stalled");

    // a held byte is not lost while the decoder cannot take it
    a_byte_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !stage_fire) |=> r_in_valid)
        else $error("input byte dropped");

endmodule

`default_nettype wire

// File: verif/utf8_stream_validator_tb.sv
// utf8_stream_validator_tb: self-checking bench for the streaming utf-8 checker
// depends on u8v_pkg, u8v_byte_if, u8v_verdict_if and utf8_stream_validator
// directed strings first, then random well-formed, damaged and noise strings under idling and stalling
`timescale 1ns / 100ps

module utf8_stream_validator_tb;

    localparam int unsigned CLK_HALF     = 2;
    localparam int unsigned RESET_CYCLES = 10;
    // settling margin after the last verdict owed has come back
    localparam int unsigned DRAIN_CYCLES = 8;
    // slowest run is far below this even with heavy stalling on both sides
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned PHASE_ITEMS  = 350;

    // kinds of character in a random string
    typedef enum int {
        CH_ASCII,
        CH_TWO,
        CH_THREE,
        CH_FOUR
    } t_char_kind;

    // ways a random string gets damaged
    typedef enum int {
        DAMAGE_BYTE,
        DAMAGE_TRUNCATE,
        DAMAGE_EXTRA
    } t_damage_kind;

    logic i_clk;
    logic i_rst_n;

    u8v_byte_if    byte_ch ();
    u8v_verdict_if verdict_ch ();

    utf8_stream_validator dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (byte_ch.sink),
        .o_verdict (verdict_ch.source)
    );

    // predictor state and the verdicts still owed by the block
    u8v_pkg::t_dec_state dec_state;
    logic                expected_verdicts[$];

    logic [7:0]  str_bytes[$];
    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned bytes_sent;
    int unsigned cycle_count;
    int unsigned error_count;

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor: one accepted byte in, maybe one verdict out
    // ------------------------------------------------------------------
    task automatic decode_byte(input logic [7:0] b, input logic fin);
        logic [u8v_pkg::CP_W-1:0] floor_cp;
        begin
            if (dec_state.pending == 2'd0) begin
                // lead byte position
                if (b[7] == 1'b0) begin
                    // plain ascii, nothing opens
                end else if (b[7:5] == u8v_pkg::LEAD2_TAG) begin
                    dec_state.pending = 2'd1;
                    dec_state.seq_len = u8v_pkg::SEQ_TWO;
                    dec_state.cp      = {16'd0, b[4:0]};
                end else if (b[7:4] == u8v_pkg::LEAD3_TAG) begin
                    dec_state.pending = 2'd2;
                    dec_state.seq_len = u8v_pkg::SEQ_THREE;
                    dec_state.cp      = {17'd0, b[3:0]};
                end else if (b[7:3] == u8v_pkg::LEAD4_TAG) begin
                    dec_state.pending = 2'd3;
                    dec_state.seq_len = u8v_pkg::SEQ_FOUR;
                    dec_state.cp      = {18'd0, b[2:0]};
                end else begin
                    // stray continuation or 11111xxx
                    dec_state.err = 1'b1;
                end
            end else if (b[7:6] != u8v_pkg::CONT_TAG) begin
                // broken sequence is dropped, next byte is a lead again
                dec_state.err     = 1'b1;
                dec_state.pending = 2'd0;
                dec_state.seq_len = u8v_pkg::SEQ_NONE;
                dec_state.cp      = '0;
            end else begin
                dec_state.cp      = {dec_state.cp[u8v_pkg::CP_W-7:0], b[5:0]};
                dec_state.pending = dec_state.pending - 2'd1;
                if (dec_state.pending == 2'd0) begin
                    // sequence complete: reject overlong forms
                    case (dec_state.seq_len)
                        u8v_pkg::SEQ_TWO:   floor_cp = u8v_pkg::FLOOR_TWO;
                        u8v_pkg::SEQ_THREE: floor_cp = u8v_pkg::FLOOR_THREE;
                        default:            floor_cp = u8v_pkg::FLOOR_FOUR;
                    endcase
                    if (dec_state.cp < floor_cp) begin
                        dec_state.err = 1'b1;
                    end
                    dec_state.seq_len = u8v_pkg::SEQ_NONE;
                    dec_state.cp      = '0;
                end
            end

            if (fin) begin
                // a sequence still open at the end of the string is an error
                if (dec_state.pending != 2'd0) begin
                    dec_state.err = 1'b1;
                end
                expected_verdicts.push_back(!dec_state.err);
                dec_state = '0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // monitors: everything is sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            decode_byte(byte_ch.data_byte, byte_ch.final_byte);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && verdict_ch.valid && verdict_ch.ready) begin
            if (expected_verdicts.size() == 0) begin
                $error("unexpected verdict: string_valid actual %0b", verdict_ch.string_valid);
                error_count++;
            end else begin
                if (verdict_ch.string_valid !== expected_verdicts[0]) begin
                    $error("string_valid mismatch: expected %0b actual %0b",
                           expected_verdicts[0], verdict_ch.string_valid);
                    error_count++;
                end
                void'(expected_verdicts.pop_front());
            end
        end
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** utf8_stream_validator: FAILED **");
            $finish;
        end
    end

    // receiver side: random backpressure, changed at the falling edge
    always @(negedge i_clk) begin
        verdict_ch.ready = ($urandom_range(0, 99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // sender helpers
    // ------------------------------------------------------------------

    // one request; returns at the edge that takes it, so valid stays up
    // until the next falling edge decides what comes next
    task automatic send_byte(input logic [7:0] b, input logic fin);
        begin
            @(negedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) begin
                byte_ch.valid = 1'b0;
                @(negedge i_clk);
            end
            byte_ch.valid      = 1'b1;
            byte_ch.data_byte  = b;
            byte_ch.final_byte = fin;
            do @(posedge i_clk); while (!byte_ch.ready);
            bytes_sent++;
        end
    endtask

    // send str_bytes as one string, final flag on the last byte
    task automatic send_string();
        begin
            for (int i = 0; i < str_bytes.size(); i++) begin
                send_byte(str_bytes[i], i == str_bytes.size() - 1);
            end
        end
    endtask

    // sender holds off until every verdict owed has come back
    task automatic wait_drained();
        begin
            @(negedge i_clk);
            byte_ch.valid = 1'b0;
            while (expected_verdicts.size() != 0) @(posedge i_clk);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------
    task automatic test_single_byte();
        begin
            str_bytes = '{8'h7F};
            send_string();
        end
    endtask

    task automatic test_two_byte();
        begin
            str_bytes = '{8'hC2, 8'h80};        // smallest legal two-byte form
            send_string();
            str_bytes = '{8'hC1, 8'hBF};        // overlong
            send_string();
        end
    endtask

    task automatic test_three_byte();
        begin
            str_bytes = '{8'hE0, 8'h9F, 8'hBF}; // overlong
            send_string();
            str_bytes = '{8'hED, 8'hA0, 8'h80}; // surrogate passes
            send_string();
        end
    endtask

    task automatic test_four_byte();
        begin
            str_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80}; // above 0x10ffff passes
            send_string();
            str_bytes = '{8'hF0, 8'h8F, 8'hBF, 8'hBF}; // overlong
            send_string();
        end
    endtask

    task automatic test_bad_lead();
        begin
            str_bytes = '{8'hFF};               // 11111xxx lead
            send_string();
            str_bytes = '{8'h80, 8'h41};        // stray continuation, later ascii cannot clear it
            send_string();
        end
    endtask

    task automatic test_bad_continuation();
        begin
            str_bytes = '{8'hC2, 8'h41};        // 0x41 ends the sequence early
            send_string();
        end
    endtask

    task automatic test_truncated();
        begin
            str_bytes = '{8'hE0, 8'hA0};        // final byte cuts the sequence off
            send_string();
        end
    endtask

    // ------------------------------------------------------------------
    // random strings: mostly well-formed characters, some damaged or noise
    // ------------------------------------------------------------------
    task automatic test_random_strings(input int unsigned idle_pct,
                                       input int unsigned stall);
        int unsigned  target;
        int unsigned  n_chars;
        t_char_kind   kind;
        t_damage_kind damage;
        logic [20:0]  cp;
        bit           in_range;
        int unsigned  pos;
        begin
            send_idle_pct = idle_pct;
            stall_pct     = stall;
            target        = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < target) begin
                str_bytes.delete();
                if ($urandom_range(0, 99) < 10) begin
                    // pure noise string
                    n_chars = $urandom_range(1, 4);
                    repeat (n_chars) str_bytes.push_back(8'($urandom));
                end else begin
                    n_chars = $urandom_range(1, 6);
                    repeat (n_chars) begin
                        kind     = t_char_kind'($urandom_range(0, 3));
                        in_range = ($urandom_range(0, 99) < 80);
                        case (kind)
                            CH_ASCII: str_bytes.push_back({1'b0, 7'($urandom)});
                            CH_TWO: begin
                                cp = in_range ? 21'($urandom_range(32'h80, 32'h7FF))
                                              : 21'($urandom & 32'h7FF);
                                str_bytes.push_back({u8v_pkg::LEAD2_TAG, cp[10:6]});
                                str_bytes.push_back({u8v_pkg::CONT_TAG, cp[5:0]});
                            end
                            CH_THREE: begin
                                cp = in_range ? 21'($urandom_range(32'h800, 32'hFFFF))
                                              : 21'($urandom & 32'hFFFF);
                                str_bytes.push_back({u8v_pkg::LEAD3_TAG, cp[15:12]});
                                str_bytes.push_back({u8v_pkg::CONT_TAG, cp[11:6]});
                                str_bytes.push_back({u8v_pkg::CONT_TAG, cp[5:0]});
                            end
                            default: begin
                                // the 4-byte form reaches 0x1fffff, past the unicode range
                                cp = in_range ? 21'($urandom_range(32'h10000, 32'h1FFFFF))
                                              : 21'($urandom & 32'h1FFFFF);
                                str_bytes.push_back({u8v_pkg::LEAD4_TAG, cp[20:18]});
                                str_bytes.push_back({u8v_pkg::CONT_TAG, cp[17:12]});
                                str_bytes.push_back({u8v_pkg::CONT_TAG, cp[11:6]});
                                str_bytes.push_back({u8v_pkg::CONT_TAG, cp[5:0]});
                            end
                        endcase
                    end
                    if ($urandom_range(0, 99) < 20) begin
                        damage = t_damage_kind'($urandom_range(0, 2));
                        case (damage)
                            DAMAGE_BYTE: begin
                                pos = $urandom_range(0, str_bytes.size() - 1);
                                str_bytes[pos] = 8'($urandom);
                            end
                            DAMAGE_TRUNCATE: begin
                                if (str_bytes.size() > 1) void'(str_bytes.pop_back());
                            end
                            default: str_bytes.push_back(8'($urandom));
                        endcase
                    end
                end
                send_string();
                // now and then let the pipe run dry mid-phase
                if ($urandom_range(0, 99) < 2) wait_drained();
            end
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        byte_ch.valid        = 1'b0;
        byte_ch.data_byte    = 8'h00;
        byte_ch.final_byte   = 1'b0;
        verdict_ch.ready     = 1'b0;
        dec_state            = '0;
        send_idle_pct        = 0;
        stall_pct            = 0;
        bytes_sent           = 0;
        cycle_count          = 0;
        error_count          = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_single_byte();
        test_two_byte();
        test_three_byte();
        test_four_byte();
        test_bad_lead();
        test_bad_continuation();
        test_truncated();
        wait_drained();

        // no idling, sender idle, receiver stalling, then both
        test_random_strings(0, 0);
        test_random_strings(48, 0);
        test_random_strings(0, 48);
        test_random_strings(22, 22);

        if (error_count == 0) begin
            $display("** utf8_stream_validator: PASSED **");
        end else begin
            $display("** utf8_stream_validator: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
design/u8v_pkg.sv
design/u8v_byte_if.sv
design/u8v_verdict_if.sv
design/u8v_step.sv
design/utf8_stream_validator.sv
verif/utf8_stream_validator_tb.sv
